### rtl/llq_pkg.sv
// Shared types, codes and defaults for the light level day/night qualifier.
`default_nettype none
package llq_pkg;

	localparam int MV_W = 12;
	localparam int CODE_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int AGREE_COUNT_DEF = 4;

	// Light levels, ordered dark to bright so the darker level is the smaller code
	localparam logic [CODE_W-1:0] LVL_NIGHT = 2'd0;
	localparam logic [CODE_W-1:0] LVL_INDET = 2'd1;
	localparam logic [CODE_W-1:0] LVL_DAY   = 2'd2;

	localparam logic [CODE_W-1:0] MODE_STARTUP = 2'd0;
	localparam logic [CODE_W-1:0] MODE_NIGHT   = 2'd1;
	localparam logic [CODE_W-1:0] MODE_DAY     = 2'd2;

	localparam logic [CODE_W-1:0] EVT_NONE  = 2'd0;
	localparam logic [CODE_W-1:0] EVT_DAY   = 2'd1;
	localparam logic [CODE_W-1:0] EVT_NIGHT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_DAY_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NIGHT_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_ENABLE   = 2'd2;

	localparam logic [MV_W-1:0] DAY_THRESHOLD_RST   = 12'd200;
	localparam logic [MV_W-1:0] NIGHT_THRESHOLD_RST = 12'd100;

	typedef logic [CODE_W-1:0] level_t;

	typedef struct packed {
		logic [MV_W-1:0] first_sensor_mv;
		logic [MV_W-1:0] second_sensor_mv;
		logic            self_test;
		logic            system_resting;
		logic            queue_ready;
	} sample_t;

	typedef struct packed {
		logic [CODE_W-1:0] event_code;
		logic [CODE_W-1:0] current_level;
		logic [CODE_W-1:0] current_mode;
	} result_t;

	typedef struct packed {
		logic second_enable;
		logic self_test;
		logic system_resting;
		logic queue_ready;
	} core_ctrl_t;

endpackage
`default_nettype wire

### rtl/light_level_day_night_qualifier.sv
// Top level of the light level day/night qualifier: config registers, lanes, core, output register.
//
// Takes one item per clock unless sample_stall holds it: each item carries one or two light
// sensor readings in mV, which two classifier lanes grade as night, indeterminate or day
// against the configured thresholds (day wins on overlap); the darker lane is kept when the
// second sensor is enabled. The level goes into a ring of the last AGREE_COUNT levels; once
// all agree (or self_test is set) on day or night, an event is raised unless the mode already
// matches (night also repeats while system_resting is low), emitted only if queue_ready was
// set on the item, in which case the mode follows it. Every item yields exactly one result,
// registered in the cycle after acceptance in a single output register. Throughput is one
// item per cycle unless the output stalls, as classify, merge, ring compare and mode decision
// are combinational. An item is still taken while a result waits if it leaves in the same cycle.
// Configuration writes are always accepted; indexes past the last register are dropped.
`default_nettype none
module light_level_day_night_qualifier #(
	parameter int AGREE_COUNT = llq_pkg::AGREE_COUNT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              sample_valid,
	output logic                                   sample_stall,
	input  wire llq_pkg::sample_t                  sample,
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output llq_pkg::result_t                       result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [llq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [llq_pkg::MV_W-1:0]          cfg_data
);

	logic [llq_pkg::MV_W-1:0] day_thr_q;
	logic [llq_pkg::MV_W-1:0] night_thr_q;
	logic                     second_en_q;

	llq_pkg::level_t     level_a;
	llq_pkg::level_t     level_b;
	llq_pkg::core_ctrl_t ctrl;
	llq_pkg::result_t    core_result;
	llq_pkg::result_t    result_q;
	logic                result_valid_q;
	logic                advance;

	// Hold the input only while a finished item is stuck in the output register
	assign sample_stall = result_valid_q && result_stall;
	assign advance      = sample_valid && !sample_stall;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_thr_q   <= llq_pkg::DAY_THRESHOLD_RST;
			night_thr_q <= llq_pkg::NIGHT_THRESHOLD_RST;
			second_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				llq_pkg::REG_DAY_THRESHOLD: begin
					day_thr_q <= cfg_data;
				end
				llq_pkg::REG_NIGHT_THRESHOLD: begin
					night_thr_q <= cfg_data;
				end
				llq_pkg::REG_SECOND_ENABLE: begin
					second_en_q <= cfg_data[0];
				end
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	// Two lanes side by side, one per sensor
	llq_lane u_lane_a (
		.day_threshold   (day_thr_q),
		.night_threshold (night_thr_q),
		.mv              (sample.first_sensor_mv),
		.level           (level_a)
	);

	llq_lane u_lane_b (
		.day_threshold   (day_thr_q),
		.night_threshold (night_thr_q),
		.mv              (sample.second_sensor_mv),
		.level           (level_b)
	);

	always_comb begin
		ctrl.second_enable  = second_en_q;
		ctrl.self_test      = sample.self_test;
		ctrl.system_resting = sample.system_resting;
		ctrl.queue_ready    = sample.queue_ready;
	end

	llq_core #(
		.AGREE_COUNT (AGREE_COUNT)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.level_a (level_a),
		.level_b (level_b),
		.ctrl    (ctrl),
		.result  (core_result)
	);

	// Output register: load on every accepted item, drop once the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= core_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("accepted item produced no result");

	a_day_event_sets_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.event_code == llq_pkg::EVT_DAY)) |->
		((result.current_mode == llq_pkg::MODE_DAY) &&
		 (result.current_level == llq_pkg::LVL_DAY)))
		else $error("day event without day mode and level");

	a_night_event_sets_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.event_code == llq_pkg::EVT_NIGHT)) |->
		((result.current_mode == llq_pkg::MODE_NIGHT) &&
		 (result.current_level == llq_pkg::LVL_NIGHT)))
		else $error("night event without night mode and level");

	a_no_event_on_busy_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !sample.queue_ready) |=> (result.event_code == llq_pkg::EVT_NONE))
		else $error("event emitted while queue not ready");
`endif

endmodule
`default_nettype wire

### rtl/llq_lane.sv
// One sensor lane: classify a millivolt reading against the two thresholds.
`default_nettype none
module llq_lane (
	input  wire logic [llq_pkg::MV_W-1:0] day_threshold,
	input  wire logic [llq_pkg::MV_W-1:0] night_threshold,
	input  wire logic [llq_pkg::MV_W-1:0] mv,
	output llq_pkg::level_t               level
);

	// Day wins where the thresholds overlap
	always_comb begin
		if (mv >= day_threshold) begin
			level = llq_pkg::LVL_DAY;
		end else if (mv <= night_threshold) begin
			level = llq_pkg::LVL_NIGHT;
		end else begin
			level = llq_pkg::LVL_INDET;
		end
	end

endmodule
`default_nettype wire

### rtl/llq_core.sv
// Lane merge, level history ring, agreement check and event/mode decision.
`default_nettype none
module llq_core #(
	parameter int AGREE_COUNT = llq_pkg::AGREE_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire llq_pkg::level_t     level_a,
	input  wire llq_pkg::level_t     level_b,
	input  wire llq_pkg::core_ctrl_t ctrl,
	output llq_pkg::result_t         result
);

	localparam int PTR_W = (AGREE_COUNT > 1) ? $clog2(AGREE_COUNT) : 1;

	llq_pkg::level_t hist_q [AGREE_COUNT];
	logic [PTR_W-1:0] ptr_q;
	llq_pkg::level_t mode_q;

	llq_pkg::level_t level;
	logic agree;
	logic [llq_pkg::CODE_W-1:0] want;
	logic fire;

	// Keep the darker of the two lanes when the second sensor is on
	always_comb begin
		level = level_a;
		if (ctrl.second_enable && (level_b < level_a)) begin
			level = level_b;
		end
	end

	// The slot being overwritten takes the new level, so only the others need checking
	always_comb begin
		agree = 1'b1;
		for (int i = 0; i < AGREE_COUNT; i++) begin
			if ((ptr_q != PTR_W'(i)) && (hist_q[i] != level)) begin
				agree = 1'b0;
			end
		end
	end

	always_comb begin
		want = llq_pkg::EVT_NONE;
		if (agree || ctrl.self_test) begin
			if (level == llq_pkg::LVL_DAY) begin
				if (mode_q != llq_pkg::MODE_DAY) begin
					want = llq_pkg::EVT_DAY;
				end
			end else if (level == llq_pkg::LVL_NIGHT) begin
				if ((mode_q != llq_pkg::MODE_NIGHT) || !ctrl.system_resting) begin
					want = llq_pkg::EVT_NIGHT;
				end
			end
		end
		fire = (want != llq_pkg::EVT_NONE) && ctrl.queue_ready;
	end

	always_comb begin
		result.current_level = level;
		result.event_code    = fire ? want : llq_pkg::EVT_NONE;
		if (!fire) begin
			result.current_mode = mode_q;
		end else if (want == llq_pkg::EVT_DAY) begin
			result.current_mode = llq_pkg::MODE_DAY;
		end else begin
			result.current_mode = llq_pkg::MODE_NIGHT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AGREE_COUNT; i++) begin
				hist_q[i] <= llq_pkg::LVL_INDET;
			end
			ptr_q  <= '0;
			mode_q <= llq_pkg::MODE_STARTUP;
		end else if (advance) begin
			hist_q[ptr_q] <= level;
			ptr_q  <= (ptr_q == PTR_W'(AGREE_COUNT - 1)) ? '0 : ptr_q + 1'b1;
			mode_q <= result.current_mode;
		end
	end

endmodule
`default_nettype wire
